// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor package
// Shared constants, operation and error codes, and the beat types that
// travel between the front end, the instruction queue and the back end.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MEM_WORDS  = 4096;
    localparam int PROG_LINES = 1024;   // power of two, at most 1 << IDX_W
    localparam int MEM_AW     = $clog2(MEM_WORDS);
    localparam int WORD_W     = 32;
    localparam int REG_AW     = 5;
    localparam int REG_COUNT  = 32;
    localparam int IDX_W      = 10;
    localparam int IQ_DEPTH   = 4;
    localparam int OQ_DEPTH   = 4;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_SUB  = 4'd1;
    localparam logic [3:0] MODE_MUL  = 4'd2;
    localparam logic [3:0] MODE_ADDI = 4'd3;
    localparam logic [3:0] MODE_SLT  = 4'd4;
    localparam logic [3:0] MODE_LW   = 4'd5;
    localparam logic [3:0] MODE_SW   = 4'd6;
    localparam logic [3:0] MODE_BEQ  = 4'd7;
    localparam logic [3:0] MODE_BNE  = 4'd8;
    localparam logic [3:0] MODE_J    = 4'd9;

    // Registers reserved for the assembler and the kernel.
    localparam logic [REG_AW-1:0] REG_AT = 5'd1;
    localparam logic [REG_AW-1:0] REG_K0 = 5'd26;
    localparam logic [REG_AW-1:0] REG_K1 = 5'd27;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_RESTRICTED = 2'd1;
    localparam logic [1:0] ERR_ADDRESS    = 2'd2;

    typedef struct packed {
        logic [3:0]              mode;
        logic [REG_AW-1:0]       dest_reg;
        logic [REG_AW-1:0]       src_a_reg;
        logic [REG_AW-1:0]       src_b_reg;
        logic signed [WORD_W-1:0] immediate;
        logic [IDX_W-1:0]        target;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        next_index;
        logic                    branch_taken;
        logic                    reg_written;
        logic [REG_AW-1:0]       written_reg;
        logic signed [WORD_W-1:0] written_value;
        logic                    mem_stored;
        logic [1:0]              error_code;
        logic [WORD_W-1:0]       instr_count;
    } out_item_t;

    // Classified instruction as it waits in the instruction queue. The second
    // read port address is the stored register for sw and src_b otherwise.
    typedef struct packed {
        logic [3:0]        mode;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [WORD_W-1:0] imm;
        logic [IDX_W-1:0]  tgt;
        logic              restricted;
    } dec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic is_restricted(input logic [REG_AW-1:0] r);
        return (r == REG_AT) || (r == REG_K0) || (r == REG_K1);
    endfunction

endpackage

// ===== hdl/mips_subset_instruction_executor_core.sv =====
// ----------------------------------------------------------------------------
// MIPS subset instruction executor core
// Usage:
//   Instruction beats enter on push/full/instr: a beat is taken at a rising
//   edge with push high and full low. Results leave on empty/pop/result: the
//   oldest result is on result while empty is low and is taken at a rising
//   edge with pop high. Every instruction beat yields exactly one result.
//   A result reaches the ports through the front register, the instruction
//   queue, the execute and write-back registers and the result queue.
//   Throughput: one instruction per cycle while results are popped, with
//   operand forwarding from write-back into execute covering dependent loads.
//   When the receiver stops popping, the four-entry result queue fills,
//   issue from the four-entry instruction queue halts and full rises once
//   the front register is also occupied; nothing is dropped.
//   Reset clears the register valid bits (registers then read as zero), the
//   instruction index and the executed count at once; the data memory is then
//   swept to zero, one word a cycle, over its 4096 words, with full held high.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_core
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  instr,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    dec_t    fe_item;
    logic    fe_push;
    q_stat_t iq_stat;
    dec_t    iq_head;
    logic    iq_pop;
    logic    clearing;

    mse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .instr    (instr),
        .full     (full),
        .clearing (clearing),
        .iq_stat  (iq_stat),
        .iq_push  (fe_push),
        .iq_item  (fe_item)
    );

    mse_iq u_iq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_item (fe_item),
        .rd_en   (iq_pop),
        .head    (iq_head),
        .stat    (iq_stat)
    );

    mse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .iq_head  (iq_head),
        .iq_stat  (iq_stat),
        .iq_pop   (iq_pop),
        .clearing (clearing),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// ===== hdl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. A read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/mse_front.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor front end
// Accepts instruction beats, checks the register fields each operation uses
// against the reserved registers and hands the classified beat to the queue.
// ----------------------------------------------------------------------------
module mse_front
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t instr,
    output logic     full,
    input  logic     clearing,
    input  q_stat_t  iq_stat,
    output logic     iq_push,
    output dec_t     iq_item
);

    logic front_v_reg;
    logic front_v_next;
    dec_t item_reg;
    dec_t dec;
    logic use_d;
    logic use_a;
    logic use_b;
    logic front_ready;
    logic accept;

    always_comb
    begin
        use_d = instr.mode inside {[MODE_ADD:MODE_SW]};
        use_a = instr.mode inside {[MODE_ADD:MODE_BNE]};
        use_b = instr.mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_SLT, MODE_BEQ, MODE_BNE};

        dec.mode = instr.mode;
        dec.rd   = instr.dest_reg;
        dec.ra   = instr.src_a_reg;
        dec.rb   = (instr.mode == MODE_SW) ? instr.dest_reg : instr.src_b_reg;
        dec.imm  = $unsigned(instr.immediate);
        dec.tgt  = instr.target;
        dec.restricted = (use_d && is_restricted(instr.dest_reg)) ||
                         (use_a && is_restricted(instr.src_a_reg)) ||
                         (use_b && is_restricted(instr.src_b_reg));
    end

    assign front_ready  = !front_v_reg || !iq_stat.full;
    assign full         = clearing || !front_ready;
    assign accept       = push && !full;
    assign front_v_next = front_ready ? accept : front_v_reg;
    assign iq_push      = front_v_reg && !iq_stat.full;
    assign iq_item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= 1'b0;
        end
        else
        begin
            front_v_reg <= front_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= dec;
        end
    end

endmodule

// ===== hdl/mse_iq.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor instruction queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mse_iq
    import mse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  dec_t    wr_item,
    input  logic    rd_en,
    output dec_t    head,
    output q_stat_t stat
);

    localparam int PW = $clog2(IQ_DEPTH);
    localparam int CW = $clog2(IQ_DEPTH + 1);

    dec_t          entry_reg [IQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(IQ_DEPTH));

endmodule

// ===== hdl/mse_back.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor back end
// Issue, execute and write-back stages with the register file, the data
// memory and its clearing sweep, and the result queue.
// ----------------------------------------------------------------------------
module mse_back
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_t      iq_head,
    input  q_stat_t   iq_stat,
    output logic      iq_pop,
    output logic      clearing,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int OQ_PW = $clog2(OQ_DEPTH);
    localparam int OQ_CW = $clog2(OQ_DEPTH + 1);
    localparam int FW    = OQ_CW + 1;
    localparam logic [WORD_W-1:0] MEM_LIMIT = WORD_W'(MEM_WORDS);
    localparam logic [IDX_W-1:0]  IDX_MASK  = IDX_W'(PROG_LINES - 1);

    // Memory clearing sweep after reset.
    logic              clr_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    // Execute stage.
    logic              ex_valid_reg;
    dec_t              ex_op_reg;
    logic              va_ok_reg;
    logic              vb_ok_reg;
    logic [WORD_W-1:0] rf_a_rdata;
    logic [WORD_W-1:0] rf_b_rdata;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;
    logic [WORD_W-1:0] sum_ai;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] ex_res;
    logic [1:0]        ex_err;
    logic              ex_taken;
    logic              ex_wr;
    logic              ex_store;
    logic [IDX_W-1:0]  ex_next;
    logic [IDX_W-1:0]  instr_index_reg;
    logic [WORD_W-1:0] exec_cnt_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;

    // Write-back stage.
    logic              wb_valid_reg;
    logic              wb_wr_reg;
    logic [REG_AW-1:0] wb_rd_reg;
    logic              wb_load_reg;
    logic [WORD_W-1:0] wb_res_reg;
    logic [IDX_W-1:0]  wb_next_reg;
    logic              wb_taken_reg;
    logic              wb_stored_reg;
    logic [1:0]        wb_err_reg;
    logic [WORD_W-1:0] wb_count_reg;
    logic [WORD_W-1:0] wb_value;
    logic              rf_we;
    out_item_t         wb_item;

    // Register write of the previous cycle, which the register file read
    // that fed the execute stage did not yet see.
    logic              last_en_reg;
    logic [REG_AW-1:0] last_rd_reg;
    logic [WORD_W-1:0] last_val_reg;

    // Data memory port.
    logic [MEM_AW-1:0] dm_addr;
    logic              dm_we;
    logic [WORD_W-1:0] dm_wdata;
    logic [WORD_W-1:0] dm_rdata;

    // Result queue.
    out_item_t         oq_entry_reg [OQ_DEPTH];
    logic [OQ_PW-1:0]  oq_wr_ptr_reg;
    logic [OQ_PW-1:0]  oq_rd_ptr_reg;
    logic [OQ_CW-1:0]  oq_count_reg;
    logic              oq_push;
    logic              oq_pop;
    logic [FW-1:0]     in_flight;
    logic              issue;

    assign clearing = clr_reg;

    // An item issues only if the result queue has room for it and for every
    // item still in the execute and write-back stages.
    assign in_flight = FW'(oq_count_reg) + FW'(ex_valid_reg) + FW'(wb_valid_reg);
    assign issue     = !iq_stat.empty && !clr_reg && (in_flight < FW'(OQ_DEPTH));
    assign iq_pop    = issue;

    assign rf_we    = wb_valid_reg && wb_wr_reg;
    assign wb_value = wb_load_reg ? dm_rdata : wb_res_reg;

    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (wb_rd_reg),
        .wdata (wb_value),
        .raddr (iq_head.ra),
        .rdata (rf_a_rdata)
    );

    mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (wb_rd_reg),
        .wdata (wb_value),
        .raddr (iq_head.rb),
        .rdata (rf_b_rdata)
    );

    always_comb
    begin
        if (rf_we && (wb_rd_reg == ex_op_reg.ra))
        begin
            op_a = wb_value;
        end
        else if (last_en_reg && (last_rd_reg == ex_op_reg.ra))
        begin
            op_a = last_val_reg;
        end
        else
        begin
            op_a = va_ok_reg ? rf_a_rdata : '0;
        end

        if (rf_we && (wb_rd_reg == ex_op_reg.rb))
        begin
            op_b = wb_value;
        end
        else if (last_en_reg && (last_rd_reg == ex_op_reg.rb))
        begin
            op_b = last_val_reg;
        end
        else
        begin
            op_b = vb_ok_reg ? rf_b_rdata : '0;
        end
    end

    always_comb
    begin
        sum_ai  = op_a + ex_op_reg.imm;
        product = op_a * op_b;

        if (ex_op_reg.restricted)
        begin
            ex_err = ERR_RESTRICTED;
        end
        else if ((ex_op_reg.mode == MODE_LW || ex_op_reg.mode == MODE_SW) &&
                 (sum_ai >= MEM_LIMIT))
        begin
            ex_err = ERR_ADDRESS;
        end
        else
        begin
            ex_err = ERR_NONE;
        end

        case (ex_op_reg.mode)
            MODE_ADD:  ex_res = op_a + op_b;
            MODE_SUB:  ex_res = op_a - op_b;
            MODE_MUL:  ex_res = product;
            MODE_ADDI: ex_res = sum_ai;
            MODE_SLT:  ex_res = {{(WORD_W - 1){1'b0}}, $signed(op_a) < $signed(op_b)};
            MODE_SW:   ex_res = op_b;
            default:   ex_res = '0;
        endcase

        case (ex_op_reg.mode)
            MODE_BEQ: ex_taken = (op_a == op_b);
            MODE_BNE: ex_taken = (op_a != op_b);
            MODE_J:   ex_taken = 1'b1;
            default:  ex_taken = 1'b0;
        endcase
        if (ex_err != ERR_NONE)
        begin
            ex_taken = 1'b0;
        end

        if (ex_err != ERR_NONE)
        begin
            ex_next = instr_index_reg;
        end
        else if (ex_taken)
        begin
            ex_next = ex_op_reg.tgt & IDX_MASK;
        end
        else
        begin
            ex_next = (instr_index_reg + 1'b1) & IDX_MASK;
        end

        ex_wr    = (ex_err == ERR_NONE) && (ex_op_reg.mode inside {[MODE_ADD:MODE_LW]}) &&
                   (ex_op_reg.rd != '0);
        ex_store = (ex_err == ERR_NONE) && (ex_op_reg.mode == MODE_SW);
    end

    // The sweep owns the data memory port until every word is zero.
    assign dm_addr  = clr_reg ? clr_addr_reg : sum_ai[MEM_AW-1:0];
    assign dm_we    = clr_reg || (ex_valid_reg && ex_store);
    assign dm_wdata = clr_reg ? '0 : op_b;

    mse_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_addr),
        .wdata (dm_wdata),
        .raddr (dm_addr),
        .rdata (dm_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= 1'b1;
            clr_addr_reg    <= '0;
            ex_valid_reg    <= 1'b0;
            va_ok_reg       <= 1'b0;
            vb_ok_reg       <= 1'b0;
            rf_valid_reg    <= '0;
            instr_index_reg <= '0;
            exec_cnt_reg    <= '0;
            wb_valid_reg    <= 1'b0;
            wb_wr_reg       <= 1'b0;
            last_en_reg     <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            ex_valid_reg <= issue;
            va_ok_reg    <= rf_valid_reg[iq_head.ra];
            vb_ok_reg    <= rf_valid_reg[iq_head.rb];
            if (rf_we)
            begin
                rf_valid_reg[wb_rd_reg] <= 1'b1;
            end
            if (ex_valid_reg)
            begin
                instr_index_reg <= ex_next;
                exec_cnt_reg    <= exec_cnt_reg + 1'b1;
            end
            wb_valid_reg <= ex_valid_reg;
            wb_wr_reg    <= ex_valid_reg && ex_wr;
            last_en_reg  <= rf_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            ex_op_reg <= iq_head;
        end
        if (ex_valid_reg)
        begin
            wb_rd_reg     <= ex_op_reg.rd;
            wb_load_reg   <= (ex_op_reg.mode == MODE_LW);
            wb_res_reg    <= ex_res;
            wb_next_reg   <= ex_next;
            wb_taken_reg  <= ex_taken;
            wb_stored_reg <= ex_store;
            wb_err_reg    <= ex_err;
            wb_count_reg  <= exec_cnt_reg + 1'b1;
        end
        last_rd_reg  <= wb_rd_reg;
        last_val_reg <= wb_value;
    end

    always_comb
    begin
        wb_item.next_index    = wb_next_reg;
        wb_item.branch_taken  = wb_taken_reg;
        wb_item.reg_written   = wb_wr_reg;
        wb_item.written_reg   = wb_wr_reg ? wb_rd_reg : '0;
        wb_item.written_value = (wb_wr_reg || wb_stored_reg) ? $signed(wb_value) : '0;
        wb_item.mem_stored    = wb_stored_reg;
        wb_item.error_code    = wb_err_reg;
        wb_item.instr_count   = wb_count_reg;
    end

    assign oq_push = wb_valid_reg;
    assign oq_pop  = pop && !empty;
    assign empty   = (oq_count_reg == '0);
    assign result  = oq_entry_reg[oq_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_ptr_reg <= (oq_wr_ptr_reg == OQ_PW'(OQ_DEPTH - 1)) ?
                                 '0 : oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= (oq_rd_ptr_reg == OQ_PW'(OQ_DEPTH - 1)) ?
                                 '0 : oq_rd_ptr_reg + 1'b1;
            end
            if (oq_push && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + 1'b1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_count_reg <= oq_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_entry_reg[oq_wr_ptr_reg] <= wb_item;
        end
    end

    // Nothing executes while the data memory is being cleared.
    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> (!ex_valid_reg && !wb_valid_reg))
        else $error("instruction in flight during memory clear");

    // The issue credit keeps the result queue from overflowing.
    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_push && !oq_pop) |-> (oq_count_reg != OQ_CW'(OQ_DEPTH)))
        else $error("result queue overflow");

    // A faulting instruction leaves registers and memory untouched.
    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_valid_reg && (ex_err != ERR_NONE)) |=> (!wb_wr_reg && !wb_stored_reg))
        else $error("write after faulting instruction");

    // The instruction index moves only when an instruction executes.
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ex_valid_reg |=> (instr_index_reg == $past(instr_index_reg)))
        else $error("instruction index changed without an instruction");

endmodule

// ===== tb/sv/mips_subset_executor_checker.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor checker
// Watches the instruction and result queues of the executor core. It keeps
// its own register file, data memory, instruction index and retired count,
// predicts one result for each instruction beat, and compares result beats
// in order, field by field.
// ----------------------------------------------------------------------------
module mips_subset_executor_checker
    import mse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  instr,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        mismatches,
    output int        outstanding,
    output int        results_seen,
    output int        restricted_seen,
    output int        bad_addr_seen,
    output int        taken_seen,
    output int        stores_seen
);

    logic [WORD_W-1:0] gpr [REG_COUNT];
    logic [WORD_W-1:0] dmem [MEM_WORDS];
    logic [IDX_W-1:0]  pc;
    logic [WORD_W-1:0] retired;
    out_item_t         expected_results [$];

    function automatic logic kernel_reg(input logic [REG_AW-1:0] r);
        return r == REG_AT || r == REG_K0 || r == REG_K1;
    endfunction

    // Runs one instruction against the shadow state and returns its result.
    function automatic out_item_t execute_instr(input in_item_t ins);
        out_item_t         res;
        logic [WORD_W-1:0] va;
        logic [WORD_W-1:0] vb;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] addr;
        logic              rd_used;
        logic              ra_used;
        logic              rb_used;
        logic              writes_reg;

        res = '0;
        va = gpr[ins.src_a_reg];
        vb = gpr[ins.src_b_reg];
        value = '0;
        writes_reg = 1'b0;
        retired = retired + 1;
        res.instr_count = retired;
        res.next_index = IDX_W'((pc + 1) % PROG_LINES);

        case (ins.mode)
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_SLT: {rd_used, ra_used, rb_used} = 3'b111;
            MODE_ADDI, MODE_LW, MODE_SW:            {rd_used, ra_used, rb_used} = 3'b110;
            MODE_BEQ, MODE_BNE:                     {rd_used, ra_used, rb_used} = 3'b011;
            default:                                {rd_used, ra_used, rb_used} = 3'b000;
        endcase

        if ((rd_used && kernel_reg(ins.dest_reg)) || (ra_used && kernel_reg(ins.src_a_reg)) ||
            (rb_used && kernel_reg(ins.src_b_reg)))
        begin
            restricted_seen++;
            res.error_code = ERR_RESTRICTED;
            res.next_index = pc;
            return res;
        end

        addr = va + ins.immediate;
        case (ins.mode)
            MODE_ADD:
            begin
                value = va + vb;
                writes_reg = 1'b1;
            end
            MODE_SUB:
            begin
                value = va - vb;
                writes_reg = 1'b1;
            end
            MODE_MUL:
            begin
                value = va * vb;
                writes_reg = 1'b1;
            end
            MODE_ADDI:
            begin
                value = va + ins.immediate;
                writes_reg = 1'b1;
            end
            MODE_SLT:
            begin
                value = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
                writes_reg = 1'b1;
            end
            MODE_LW, MODE_SW:
            begin
                // The address is unsigned, so a negative sum lands far above the memory.
                if (addr >= MEM_WORDS)
                begin
                    bad_addr_seen++;
                    res.error_code = ERR_ADDRESS;
                    res.next_index = pc;
                    return res;
                end
                if (ins.mode == MODE_LW)
                begin
                    value = dmem[addr[MEM_AW-1:0]];
                    writes_reg = 1'b1;
                end
                else
                begin
                    dmem[addr[MEM_AW-1:0]] = gpr[ins.dest_reg];
                    res.mem_stored = 1'b1;
                    res.written_value = gpr[ins.dest_reg];
                    stores_seen++;
                end
            end
            MODE_BEQ, MODE_BNE, MODE_J:
            begin
                if (ins.mode == MODE_J || ((va == vb) == (ins.mode == MODE_BEQ)))
                begin
                    res.branch_taken = 1'b1;
                    res.next_index = IDX_W'(ins.target % PROG_LINES);
                    taken_seen++;
                end
            end
            default:
            begin
            end
        endcase

        if (writes_reg && ins.dest_reg != '0)
        begin
            gpr[ins.dest_reg] = value;
            res.reg_written = 1'b1;
            res.written_reg = ins.dest_reg;
            res.written_value = value;
        end
        pc = res.next_index;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_result(input out_item_t want, input out_item_t got);
        check_field("next_index", want.next_index, got.next_index);
        check_field("branch_taken", want.branch_taken, got.branch_taken);
        check_field("reg_written", want.reg_written, got.reg_written);
        check_field("written_reg", want.written_reg, got.written_reg);
        check_field("written_value", want.written_value, got.written_value);
        check_field("mem_stored", want.mem_stored, got.mem_stored);
        check_field("error_code", want.error_code, got.error_code);
        check_field("instr_count", want.instr_count, got.instr_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t oldest;

        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                gpr[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                dmem[i] = '0;
            pc = '0;
            retired = '0;
            expected_results.delete();
            mismatches = 0;
            results_seen = 0;
            restricted_seen = 0;
            bad_addr_seen = 0;
            taken_seen = 0;
            stores_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat arrived with no instruction waiting for it");
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_result(oldest, result);
                end
            end
            if (push && !full)
                expected_results.push_back(execute_instr(instr));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/mips_subset_instruction_executor_core_test.sv =====
// ----------------------------------------------------------------------------
// MIPS subset executor core testbench
// Sends a directed set of corner-case instructions, then random ones and
// store/load/branch sequences up to about two thousand beats in all, mostly
// with safe registers and reachable addresses. Both queues idle at random; the
// result side also holds off long enough to back the core up. A checker module
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_core_test
    import mse_pkg::*;
();

    localparam int ITEM_COUNT     = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_AT        = 600;
    localparam int PAUSE_AT       = 1300;

    localparam logic [REG_AW-1:0] REG_ZERO    = 5'd0;
    localparam logic [3:0]        MODE_UNUSED = 4'd15;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  instr = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    int mismatches;
    int outstanding;
    int results_seen;
    int restricted_seen;
    int bad_addr_seen;
    int taken_seen;
    int stores_seen;

    int sent = 0;
    int hold_asks = 0;
    int holds_done = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    mips_subset_instruction_executor_core i_dut (
        .clk,
        .rst_n,
        .push,
        .full,
        .instr,
        .empty,
        .pop,
        .result
    );

    mips_subset_executor_checker i_checker (
        .clk,
        .rst_n,
        .push,
        .full,
        .instr,
        .empty,
        .pop,
        .result,
        .mismatches,
        .outstanding,
        .results_seen,
        .restricted_seen,
        .bad_addr_seen,
        .taken_seen,
        .stores_seen
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int roll;

        roll = $urandom_range(99, 0);
        if (roll < 75)
            return $urandom_range(3, 1);
        if (roll < 95)
            return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    function automatic logic [REG_AW-1:0] pick_safe();
        logic [REG_AW-1:0] r;

        do
            r = REG_AW'($urandom_range(31, 1));
        while (r == REG_AT || r == REG_K0 || r == REG_K1);
        return r;
    endfunction

    function automatic logic [REG_AW-1:0] pick_reg();
        int roll;

        roll = $urandom_range(99, 0);
        if (roll < 8)
            return REG_ZERO;
        if (roll < 90)
            return pick_safe();
        if (roll < 97)
            return REG_AW'($urandom_range(31, 0));
        case ($urandom_range(2, 0))
            0:       return REG_AT;
            1:       return REG_K0;
            default: return REG_K1;
        endcase
    endfunction

    function automatic in_item_t make_instr(input logic [3:0] mode,
                                            input logic [REG_AW-1:0] rd, ra, rb,
                                            input logic [WORD_W-1:0] imm,
                                            input logic [IDX_W-1:0] tgt);
        in_item_t ins;

        ins.mode = mode;
        ins.dest_reg = rd;
        ins.src_a_reg = ra;
        ins.src_b_reg = rb;
        ins.immediate = imm;
        ins.target = tgt;
        return ins;
    endfunction

    function automatic in_item_t random_instr();
        in_item_t ins;
        int       roll;

        ins.mode = 4'($urandom_range(MODE_J, MODE_ADD));
        if ($urandom_range(99, 0) < 5)
            ins.mode = 4'($urandom_range(MODE_UNUSED, MODE_J + 1));
        ins.dest_reg = pick_reg();
        ins.src_a_reg = pick_reg();
        ins.src_b_reg = pick_reg();
        ins.target = IDX_W'($urandom_range(PROG_LINES - 1, 0));
        roll = $urandom_range(99, 0);
        if (roll < 35)
            ins.immediate = $urandom_range(32, 0) - 16;
        else if (roll < 65)
            ins.immediate = $urandom_range(MEM_WORDS - 1, 0);
        else if (roll < 75)
            ins.immediate = $urandom_range(MEM_WORDS + 1, MEM_WORDS - 2);
        else
            ins.immediate = $urandom();
        // A zero base keeps most memory accesses inside the store.
        if ((ins.mode == MODE_LW || ins.mode == MODE_SW) && $urandom_range(99, 0) < 60)
            ins.src_a_reg = REG_ZERO;
        if ((ins.mode == MODE_BEQ || ins.mode == MODE_BNE) && $urandom_range(99, 0) < 30)
            ins.src_b_reg = ins.src_a_reg;
        return ins;
    endfunction

    // Holds the beat on the port until the core takes it.
    task automatic send_instr(input in_item_t item);
        push <= 1'b1;
        instr <= item;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Sets a base, stores a register, loads it back and branches on the match.
    task automatic send_mem_sequence();
        logic [REG_AW-1:0] base_r;
        logic [REG_AW-1:0] data_r;
        logic [REG_AW-1:0] load_r;
        logic [WORD_W-1:0] base_val;
        logic [WORD_W-1:0] offset;

        base_r = pick_safe();
        data_r = pick_reg();
        load_r = pick_safe();
        base_val = $urandom_range(MEM_WORDS - 1, 0);
        offset = $urandom_range(64, 0) - 32;
        send_instr(make_instr(MODE_ADDI, base_r, REG_ZERO, REG_ZERO, base_val, '0));
        send_instr(make_instr(MODE_SW, data_r, base_r, REG_ZERO, offset, '0));
        send_instr(make_instr(MODE_LW, load_r, base_r, REG_ZERO, offset, '0));
        send_instr(make_instr(MODE_BEQ, REG_ZERO, load_r, data_r, '0,
                              IDX_W'($urandom_range(PROG_LINES - 1, 0))));
    endtask

    // Result side: random stalls, plus one long hold when the stimulus asks.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_left = 0;
            holds_done = 0;
        end
        else if (holds_done != hold_asks)
        begin
            holds_done = hold_asks;
            stall_left = LONG_HOLD;
            pop <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if ($urandom_range(99, 0) < 12)
        begin
            stall_left = idle_len() - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        bit calm;
        bit hold_issued;
        bit paused;

        hold_issued = 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Corner cases: wrapping arithmetic, signed compare, register zero,
        // memory edges, reserved registers, branch outcomes and index wrap.
        send_instr(make_instr(MODE_ADD, 5'd2, REG_ZERO, REG_ZERO, '0, '0));
        send_instr(make_instr(MODE_ADDI, 5'd2, REG_ZERO, REG_ZERO, 32'h7FFF_FFFF, '0));
        send_instr(make_instr(MODE_ADDI, 5'd3, REG_ZERO, REG_ZERO, 32'h8000_0000, '0));
        send_instr(make_instr(MODE_ADD, 5'd4, 5'd2, 5'd2, '0, '0));
        send_instr(make_instr(MODE_SUB, 5'd5, 5'd3, 5'd2, '0, '0));
        send_instr(make_instr(MODE_MUL, 5'd6, 5'd2, 5'd3, '0, '0));
        send_instr(make_instr(MODE_SLT, 5'd7, 5'd3, 5'd2, '0, '0));
        send_instr(make_instr(MODE_SLT, 5'd8, 5'd2, 5'd3, '0, '0));
        send_instr(make_instr(MODE_ADDI, REG_ZERO, 5'd2, REG_ZERO, 32'd5, '0));
        send_instr(make_instr(MODE_ADDI, 5'd9, REG_ZERO, REG_ZERO, 32'hFFFF_FFFF, '0));
        send_instr(make_instr(MODE_SW, 5'd2, 5'd9, REG_ZERO, 32'd1, '0));
        send_instr(make_instr(MODE_LW, 5'd10, REG_ZERO, REG_ZERO, '0, '0));
        send_instr(make_instr(MODE_SW, 5'd3, REG_ZERO, REG_ZERO, WORD_W'(MEM_WORDS - 1), '0));
        send_instr(make_instr(MODE_LW, 5'd11, REG_ZERO, REG_ZERO, WORD_W'(MEM_WORDS - 1), '0));
        send_instr(make_instr(MODE_LW, 5'd12, REG_ZERO, REG_ZERO, WORD_W'(MEM_WORDS), '0));
        send_instr(make_instr(MODE_SW, 5'd2, REG_ZERO, REG_ZERO, 32'hFFFF_FFFF, '0));
        send_instr(make_instr(MODE_ADD, REG_AT, 5'd2, 5'd3, '0, '0));
        send_instr(make_instr(MODE_LW, 5'd12, REG_K0, REG_ZERO, '0, '0));
        send_instr(make_instr(MODE_BEQ, REG_ZERO, REG_K1, 5'd2, '0, 10'd5));
        send_instr(make_instr(MODE_BEQ, REG_ZERO, 5'd2, 5'd2, '0, IDX_W'(PROG_LINES - 1)));
        send_instr(make_instr(MODE_BNE, REG_ZERO, 5'd2, 5'd2, '0, 10'd7));
        send_instr(make_instr(MODE_BNE, REG_ZERO, 5'd2, 5'd3, '0, '0));
        send_instr(make_instr(MODE_J, REG_K1, REG_AT, REG_K0, '0, 10'd512));
        send_instr(make_instr(MODE_UNUSED, REG_AT, REG_K0, REG_K1, 32'hFFFF_FFFF, '1));
        wait_all_results();

        while (sent < ITEM_COUNT)
        begin
            // Every fourth block of beats and the long hold run without gaps.
            calm = ((sent / 100) % 4 == 3) || (hold_issued && sent < HOLD_AT + 40);
            if (!hold_issued && sent >= HOLD_AT)
            begin
                hold_issued = 1'b1;
                hold_asks++;
                calm = 1'b1;
            end
            if (!paused && sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                wait_all_results();
            end
            if ($urandom_range(99, 0) < 30)
                send_mem_sequence();
            else
                send_instr(random_instr());
            if (!calm && $urandom_range(99, 0) < 25)
            begin
                push <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d instructions and checked %0d results, %0d of them stores.",
                 sent, results_seen, stores_seen);
        $display("Seen %0d reserved-register errors, %0d bad addresses, %0d taken branches.",
                 restricted_seen, bad_addr_seen, taken_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/mse_front.sv
hdl/mse_iq.sv
hdl/mse_back.sv
hdl/mips_subset_instruction_executor_core.sv
tb/sv/mips_subset_executor_checker.sv
tb/sv/mips_subset_instruction_executor_core_test.sv
